@@ rtl/wvpb_pkg.sv @@
`default_nettype none

package wvpb_pkg;

  // one candidate sample of a target pixel
  typedef struct packed {
    logic [15:0] sample_depth;
    logic [9:0]  color_r;
    logic [9:0]  color_g;
    logic [9:0]  color_b;
    logic [15:0] ray_angle;
    logic [15:0] stretch_amount;
    logic        last_sample;
  } sample_t;

  // blended pixel
  typedef struct packed {
    logic        has_value;
    logic [9:0]  out_r;
    logic [9:0]  out_g;
    logic [9:0]  out_b;
    logic [15:0] out_depth;
    logic [23:0] quality;
    logic [15:0] validity;
  } result_t;

  // register file
  typedef logic [1:0] reg_index_t;

  localparam reg_index_t REG_RAY_ANGLE_GAIN  = 2'd0;
  localparam reg_index_t REG_DEPTH_GAIN      = 2'd1;
  localparam reg_index_t REG_STRETCH_GAIN    = 2'd2;
  localparam reg_index_t REG_DEPTH_ONLY_MODE = 2'd3;

  typedef struct packed {
    reg_index_t  index;
    logic [15:0] wdata;
  } cfg_write_t;

  localparam logic [15:0] RAY_ANGLE_GAIN_RESET = 16'd2560;
  localparam logic [15:0] DEPTH_GAIN_RESET     = 16'd2560;
  localparam logic [15:0] STRETCH_GAIN_RESET   = 16'd0;

  // log2(e) in Q2.30
  localparam logic [32:0] LOG2E_Q30 = 33'd1549082005;
  // exp(+x) ceiling, 65536.0 in Q.16
  localparam logic [32:0] POS_CAP   = 33'h1_0000_0000;
  localparam logic [23:0] W_MAX     = 24'hFF_FFFF;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_E1,
    S_E2,
    S_NEW,
    S_WAB,
    S_NUM,
    S_ALPHA,
    S_THR,
    S_W1,
    S_W1M,
    S_W2A,
    S_W2M,
    S_LERP,
    S_STORE,
    S_KEEPB,
    S_LAST,
    S_ODEP,
    S_OEXP,
    S_OVAL,
    S_EMIT,
    S_DIV,
    S_EXARG,
    S_EXCHK,
    S_EXROOT,
    S_EXFIN
  } state_t;

  // 2^(-2^-j) in Q0.32 by a chain of truncated square roots, elaboration only
  function automatic logic [31:0] root_const(input int unsigned j);
    logic [63:0] prev;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bitv;
    prev = 64'd1 << 31;
    for (int unsigned k = 1; k <= j; k++) begin
      n    = prev << 32;
      res  = 64'd0;
      bitv = 64'd1 << 62;
      for (int s = 0; s < 32; s++) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      prev = res;
    end
    return prev[31:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/wvpb_if.sv @@
`default_nettype none

// sample channel
interface wvpb_in_if import wvpb_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// result channel
interface wvpb_out_if import wvpb_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// register write channel
interface wvpb_cfg_if import wvpb_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_write_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/weighted_view_pixel_blender.sv @@
`default_nettype none

// Depth-weighted blender for the candidate samples of one target pixel. Each sample beat
// with nonzero depth gets a weight exp(-ray*angle)*exp(-stretch*stretching) and disparity
// 1/depth, and is merged into a running accumulator; a beat with last_sample set emits one
// result beat and empties the accumulator. Products, but for the threshold scaling by 100, use
// one 33x33 multiplier and a one-bit-per-cycle divider under a sequencer, so samples are taken
// one at a time and the sample channel is not ready while a sample is in work. A finished
// result is held in an output register, so the next sample is accepted while it waits to be
// taken.
module weighted_view_pixel_blender import wvpb_pkg::*; #(
  parameter int unsigned EXP_TABLE_BITS = 10
) (
  input  wire          clk,
  input  wire          rst,
  wvpb_in_if.sink      samples,
  wvpb_out_if.source   results,
  wvpb_cfg_if.sink     cfg
);

  localparam int unsigned CNT_W = $clog2(EXP_TABLE_BITS);

  // root constants of the fraction product
  logic [31:0] root_tab [EXP_TABLE_BITS];
  for (genvar g = 0; g < EXP_TABLE_BITS; g++) begin : g_root
    localparam logic [31:0] RootVal = root_const(g + 1);
    assign root_tab[g] = RootVal;
  end

  // configuration
  logic [15:0] ray_gain;
  logic [15:0] depth_gain;
  logic [15:0] stretch_gain;
  logic        depth_only;

  // accumulator
  logic        acc_valid;
  logic [23:0] acc_w;
  logic [23:0] acc_d;
  logic [15:0] acc_c [3];
  logic [15:0] acc_ang;
  logic [15:0] acc_str;

  // current sample and its entry
  sample_t     sample;
  logic [15:0] n_c [3];
  logic [16:0] t1;
  logic [23:0] n_w;
  logic [23:0] n_d;

  // ordered entries of a merge
  logic [23:0] a_w, b_w, a_d, b_d;
  logic [15:0] a_c [3];
  logic [15:0] b_c [3];
  logic [15:0] a_ang, b_ang, a_str, b_str;

  // merge intermediates and merged entry
  logic [23:0] num;
  logic [24:0] den;
  logic [16:0] alpha;
  logic [23:0] nd;
  logic [24:0] w1;
  logic [41:0] w_sum;
  logic [23:0] m_w, m_d;
  logic [15:0] m_c [3];
  logic [15:0] m_ang, m_str;
  logic [2:0]  k;

  // exp unit
  logic [39:0]                ex_x;
  logic                       ex_pos;
  state_t                     ex_ret;
  logic [6:0]                 ex_i;
  logic [EXP_TABLE_BITS-1:0]  ex_fb;
  logic [EXP_TABLE_BITS-1:0]  ex_f;
  logic [31:0]                ex_r;
  logic [CNT_W-1:0]           ex_cnt;
  logic [32:0]                ex_res;
  logic [47:0]                ex_wide;
  logic [32:0]                ex_posv;

  // divider
  logic [39:0] dv_q;
  logic [24:0] dv_rem;
  logic [24:0] dv_den;
  logic [5:0]  dv_cnt;
  state_t      dv_ret;
  logic [25:0] dv_t;
  logic        dv_ge;

  // shared multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;

  // lerp datapath
  logic [15:0] lx1, lx2, l_diff, l_step, l_res;
  logic        l_up;

  // sequencer and output register
  state_t  state, state_next;
  result_t result;
  logic    result_valid;
  logic    out_busy;
  logic    below_thr;

  // rounded 10-bit code from a Q10.6 color
  function automatic logic [9:0] color_out(input logic [15:0] c);
    logic [16:0] s;
    s = {1'b0, c} + 17'd32;
    return (s[16:6] > 11'd1023) ? 10'd1023 : s[15:6];
  endfunction

  assign n_c[0]   = {sample.color_r, 6'b0};
  assign n_c[1]   = {sample.color_g, 6'b0};
  assign n_c[2]   = {sample.color_b, 6'b0};
  assign mul_p    = mul_a * mul_b;
  assign den      = {1'b0, num} + {1'b0, b_w};
  assign w_sum    = {17'b0, w1} + {1'b0, mul_p[56:16]};
  assign out_busy = result_valid && !results.ready;
  assign below_thr = ({7'b0, dv_q[16:0]} * 24'd100) < 24'd65536;

  assign dv_t  = {dv_rem, dv_q[39]};
  assign dv_ge = dv_t >= {1'b0, dv_den};

  assign ex_wide = {16'b0, ex_r} << ({1'b0, ex_i[3:0]} + 5'd1);
  assign ex_posv = ex_wide[47:15];

  assign results.valid = result_valid;
  assign results.data  = result;

  // lerp operand select, toward x1 = b
  always_comb begin
    unique case (k)
      3'd0:    begin lx1 = b_c[0]; lx2 = a_c[0]; end
      3'd1:    begin lx1 = b_c[1]; lx2 = a_c[1]; end
      3'd2:    begin lx1 = b_c[2]; lx2 = a_c[2]; end
      3'd3:    begin lx1 = b_ang;  lx2 = a_ang;  end
      default: begin lx1 = b_str;  lx2 = a_str;  end
    endcase
    l_up   = lx2 >= lx1;
    l_diff = l_up ? lx2 - lx1 : lx1 - lx2;
    l_step = mul_p[31:16];
    l_res  = l_up ? lx1 + l_step : lx1 - l_step;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (samples.valid) begin
                  state_next = (samples.data.sample_depth == 16'd0) ? S_LAST : S_DIV;
                end
      S_DIV:    if (dv_cnt == 6'd1) state_next = dv_ret;
      S_DISP:   state_next = S_EXARG;
      S_E1:     state_next = S_EXARG;
      S_E2:     state_next = S_NEW;
      S_NEW:    state_next = acc_valid ? S_WAB : S_LAST;
      S_WAB:    state_next = S_EXARG;
      S_NUM:    state_next = S_ALPHA;
      S_ALPHA:  state_next = (den == 25'd0) ? S_KEEPB : S_DIV;
      S_THR:    state_next = below_thr ? S_KEEPB : S_W1;
      S_W1:     state_next = S_EXARG;
      S_W1M:    state_next = S_W2A;
      S_W2A:    state_next = S_EXARG;
      S_W2M:    state_next = depth_only ? S_STORE : S_LERP;
      S_LERP:   if (k == 3'd4) state_next = S_STORE;
      S_STORE:  state_next = S_LAST;
      S_KEEPB:  state_next = S_LAST;
      S_LAST: begin
        priority if (!sample.last_sample)           state_next = S_IDLE;
        else if (out_busy)                          state_next = S_LAST;
        else if (!acc_valid || acc_w == 24'd0)      state_next = S_EMIT;
        else if (acc_d == 24'd0)                    state_next = S_OEXP;
        else                                        state_next = S_DIV;
      end
      S_ODEP:   state_next = S_OEXP;
      S_OEXP:   state_next = S_EXARG;
      S_OVAL:   state_next = S_EMIT;
      S_EMIT:   state_next = S_IDLE;
      S_EXARG:  state_next = (ex_x[39:30] != 10'd0) ? ex_ret : S_EXCHK;
      S_EXCHK: begin
        if (!ex_pos) begin
          state_next = (ex_i >= 7'd32) ? ex_ret : S_EXROOT;
        end else begin
          state_next = (ex_i >= 7'd16 || ex_fb == '0) ? ex_ret : S_EXROOT;
        end
      end
      S_EXROOT: if (ex_cnt == CNT_W'(EXP_TABLE_BITS - 1)) state_next = S_EXFIN;
      S_EXFIN:  state_next = ex_ret;
      default:  state_next = S_IDLE;
    endcase
  end

  // handshakes and multiplier operands
  always_comb begin
    samples.ready = (state == S_IDLE);
    cfg.ready     = 1'b1;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state)
      S_DISP:   begin mul_a = {17'b0, ray_gain};     mul_b = {17'b0, sample.ray_angle};      end
      S_E1:     begin mul_a = {17'b0, stretch_gain}; mul_b = {17'b0, sample.stretch_amount}; end
      S_E2:     begin mul_a = {16'b0, t1};           mul_b = ex_res;                         end
      S_WAB:    begin mul_a = {17'b0, depth_gain};   mul_b = {9'b0, b_d - a_d};              end
      S_NUM:    begin mul_a = ex_res;                mul_b = {9'b0, a_w};                    end
      S_THR:    begin mul_a = {16'b0, dv_q[16:0]};   mul_b = {9'b0, b_d - a_d};              end
      S_W1:     begin mul_a = {17'b0, depth_gain};   mul_b = {9'b0, nd - a_d};               end
      S_W1M:    begin mul_a = {9'b0, a_w};           mul_b = ex_res;                         end
      S_W2A:    begin mul_a = {17'b0, depth_gain};   mul_b = {9'b0, b_d - nd};               end
      S_W2M:    begin mul_a = {9'b0, b_w};           mul_b = ex_res;                         end
      S_LERP:   begin mul_a = {16'b0, alpha};        mul_b = {17'b0, l_diff};                end
      S_OEXP:   begin mul_a = {17'b0, stretch_gain}; mul_b = {17'b0, acc_str};              end
      S_EXARG:  begin mul_a = {3'b0, ex_x[29:0]};    mul_b = LOG2E_Q30;                      end
      S_EXROOT: begin mul_a = {1'b0, ex_r};          mul_b = {1'b0, root_tab[ex_cnt]};       end
      default:  begin mul_a = '0;                    mul_b = '0;                             end
    endcase
  end

  // sequencer, configuration and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      acc_valid    <= 1'b0;
      result_valid <= 1'b0;
      ray_gain     <= RAY_ANGLE_GAIN_RESET;
      depth_gain   <= DEPTH_GAIN_RESET;
      stretch_gain <= STRETCH_GAIN_RESET;
      depth_only   <= 1'b0;
    end else begin
      state <= state_next;

      // register writes
      if (cfg.valid) begin
        unique case (cfg.data.index)
          REG_RAY_ANGLE_GAIN:  ray_gain     <= cfg.data.wdata;
          REG_DEPTH_GAIN:      depth_gain   <= cfg.data.wdata;
          REG_STRETCH_GAIN:    stretch_gain <= cfg.data.wdata;
          REG_DEPTH_ONLY_MODE: depth_only   <= cfg.data.wdata[0];
          default:             depth_only   <= depth_only;
        endcase
      end

      // result beat
      if (state == S_EMIT) begin
        result_valid <= 1'b1;
      end else if (results.ready) begin
        result_valid <= 1'b0;
      end

      // accumulator occupancy
      if (state == S_NEW || state == S_STORE || state == S_KEEPB) begin
        acc_valid <= 1'b1;
      end else if (state == S_EMIT) begin
        acc_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        sample <= samples.data;
        dv_q   <= 40'd1 << 39;
        dv_rem <= '0;
        dv_den <= {9'b0, samples.data.sample_depth};
        dv_cnt <= 6'd25;
        dv_ret <= S_DISP;
      end
      S_DIV: begin
        dv_rem <= dv_ge ? 25'(dv_t - {1'b0, dv_den}) : dv_t[24:0];
        dv_q   <= {dv_q[38:0], dv_ge};
        dv_cnt <= dv_cnt - 6'd1;
      end
      S_DISP: begin
        n_d    <= dv_q[24] ? W_MAX : dv_q[23:0];
        ex_x   <= {6'b0, mul_p[31:0], 2'b0};
        ex_pos <= 1'b0;
        ex_ret <= S_E1;
      end
      S_E1: begin
        t1     <= ex_res[16:0];
        ex_x   <= {4'b0, mul_p[31:0], 4'b0};
        ex_pos <= 1'b0;
        ex_ret <= S_E2;
      end
      S_E2: n_w <= mul_p[39:16];
      S_NEW: begin
        priority if (!acc_valid) begin
          acc_w   <= n_w;
          acc_d   <= n_d;
          acc_c   <= n_c;
          acc_ang <= sample.ray_angle;
          acc_str <= sample.stretch_amount;
        end else if (acc_d > n_d) begin
          a_w <= n_w;   a_d <= n_d;   a_c <= n_c;
          a_ang <= sample.ray_angle; a_str <= sample.stretch_amount;
          b_w <= acc_w; b_d <= acc_d; b_c <= acc_c;
          b_ang <= acc_ang; b_str <= acc_str;
        end else begin
          a_w <= acc_w; a_d <= acc_d; a_c <= acc_c;
          a_ang <= acc_ang; a_str <= acc_str;
          b_w <= n_w;   b_d <= n_d;   b_c <= n_c;
          b_ang <= sample.ray_angle; b_str <= sample.stretch_amount;
        end
      end
      S_WAB: begin
        ex_x   <= mul_p[39:0];
        ex_pos <= 1'b0;
        ex_ret <= S_NUM;
      end
      S_NUM: num <= mul_p[39:16];
      S_ALPHA: begin
        dv_q   <= {num, 16'b0};
        dv_rem <= '0;
        dv_den <= den;
        dv_cnt <= 6'd40;
        dv_ret <= S_THR;
      end
      S_THR: begin
        alpha <= dv_q[16:0];
        nd    <= b_d - mul_p[39:16];
      end
      S_W1: begin
        ex_x   <= mul_p[39:0];
        ex_pos <= 1'b0;
        ex_ret <= S_W1M;
      end
      S_W1M: w1 <= mul_p[40:16];
      S_W2A: begin
        ex_x   <= mul_p[39:0];
        ex_pos <= 1'b1;
        ex_ret <= S_W2M;
      end
      S_W2M: begin
        m_w <= (w_sum > {18'b0, W_MAX}) ? W_MAX : w_sum[23:0];
        m_d <= nd;
        k   <= 3'd0;
        if (depth_only) begin
          m_c[0] <= '0; m_c[1] <= '0; m_c[2] <= '0;
          m_ang  <= '0;
          m_str  <= '0;
        end
      end
      S_LERP: begin
        unique case (k)
          3'd0:    m_c[0] <= l_res;
          3'd1:    m_c[1] <= l_res;
          3'd2:    m_c[2] <= l_res;
          3'd3:    m_ang  <= l_res;
          default: m_str  <= l_res;
        endcase
        k <= k + 3'd1;
      end
      S_STORE: begin
        acc_w <= m_w; acc_d <= m_d; acc_c <= m_c;
        acc_ang <= m_ang; acc_str <= m_str;
      end
      S_KEEPB: begin
        acc_w <= b_w; acc_d <= b_d; acc_c <= b_c;
        acc_ang <= b_ang; acc_str <= b_str;
      end
      S_LAST: begin
        // output register is free here, fill the payload
        if (sample.last_sample && !out_busy) begin
          if (acc_valid && acc_w != 24'd0) begin
            result.has_value <= 1'b1;
            result.out_r     <= depth_only ? 10'd0 : color_out(acc_c[0]);
            result.out_g     <= depth_only ? 10'd0 : color_out(acc_c[1]);
            result.out_b     <= depth_only ? 10'd0 : color_out(acc_c[2]);
            result.out_depth <= 16'hFFFF;
            result.quality   <= acc_w;
            result.validity  <= '0;
          end else begin
            result <= '0;
          end
          dv_q   <= 40'd1 << 39;
          dv_rem <= '0;
          dv_den <= {1'b0, acc_d};
          dv_cnt <= 6'd25;
          dv_ret <= S_ODEP;
        end
      end
      S_ODEP: result.out_depth <= (dv_q[24:16] != 9'd0) ? 16'hFFFF : dv_q[15:0];
      S_OEXP: begin
        ex_x   <= {4'b0, mul_p[31:0], 4'b0};
        ex_pos <= 1'b0;
        ex_ret <= S_OVAL;
      end
      S_OVAL: result.validity <= ex_res[16] ? 16'hFFFF : ex_res[15:0];
      S_EXARG: begin
        if (ex_x[39:30] != 10'd0) begin
          ex_res <= ex_pos ? POS_CAP : 33'd0;
        end
        ex_i  <= mul_p[60:54];
        ex_fb <= mul_p[53 -: EXP_TABLE_BITS];
      end
      S_EXCHK: begin
        ex_r   <= 32'h8000_0000;
        ex_cnt <= '0;
        if (!ex_pos) begin
          if (ex_i >= 7'd32) ex_res <= 33'd0;
          ex_f <= ex_fb;
        end else begin
          priority if (ex_i >= 7'd16) ex_res <= POS_CAP;
          else if (ex_fb == '0)       ex_res <= 33'd1 << (5'd16 + {1'b0, ex_i[3:0]});
          else                        ex_res <= ex_res;
          ex_f <= ~ex_fb + 1'b1;
        end
      end
      S_EXROOT: begin
        if (ex_f[EXP_TABLE_BITS-1]) ex_r <= mul_p[63:32];
        ex_f   <= ex_f << 1;
        ex_cnt <= ex_cnt + 1'b1;
      end
      S_EXFIN: begin
        if (!ex_pos) begin
          ex_res <= {16'b0, 17'((ex_r >> ex_i[4:0]) >> 15)};
        end else begin
          ex_res <= (ex_posv > POS_CAP) ? POS_CAP : ex_posv;
        end
      end
      default: ;
    endcase
  end

  // a sample beat always starts a multi-cycle pass
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("sample channel ready right after a take");

  a_quality_nonzero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.has_value |-> results.data.quality != 24'd0)
    else $error("result with value but zero weight");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.data.has_value |->
      results.data.out_depth == 16'd0 && results.data.quality == 24'd0 &&
      results.data.validity == 16'd0)
    else $error("empty result carries data");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> dv_cnt != 6'd0)
    else $error("divider ran past its count");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> !results.valid)
    else $error("result overwritten while still waiting");

endmodule

`default_nettype wire
